// ----- src/mtgp_pkg.sv -----
// Shared types and constants for the markup text glyph placer.
// No dependencies; imported by mtgp_step, markup_text_glyph_placer and the testbench.
package mtgp_pkg;

  localparam logic [11:0] LEFT_MARGIN = 12'd20;
  localparam logic [11:0] TOP_GAP     = 12'd20;
  localparam logic [11:0] GLYPH_W     = 12'd8;
  localparam logic [11:0] LINE_H      = 12'd16;
  localparam logic [11:0] ROW_MAX     = 12'd4095;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_H_LO  = 8'h68;
  localparam logic [7:0] CH_H_UP  = 8'h48;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd1024;
  localparam logic [9:0]  RST_BAR_HEIGHT    = 10'd40;
  localparam logic [23:0] RST_TEXT_COLOR    = 24'hFFFFFF;
  localparam logic [23:0] RST_HEADING_COLOR = 24'hF9E2AF;
  localparam logic [23:0] RST_LINK_COLOR    = 24'h89B4FA;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_BAR_HEIGHT    = 3'd1,
    REG_TEXT_COLOR    = 3'd2,
    REG_HEADING_COLOR = 3'd3,
    REG_LINK_COLOR    = 3'd4,
    REG_SKIP_HEADER   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [11:0] screen_width;
    logic [9:0]  bar_height;
    logic [23:0] text_color;
    logic [23:0] heading_color;
    logic [23:0] link_color;
    logic        skip_header;
  } cfg_regs_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  ch;
    logic [23:0] color;
  } glyph_t;

endpackage

// ----- src/mtgp_step.sv -----
// Parse state and cursor of the glyph placer: one byte per accepted word.
// Depends on mtgp_pkg for constants and the config and glyph structs.
module mtgp_step import mtgp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] byte_in,
  input  logic      page_start,
  input  cfg_regs_t cfg,
  output logic      emit,
  output glyph_t    glyph
);

  logic [2:0]  header_progress, header_progress_next;
  logic        in_body, in_body_next;
  logic        inside_tag, inside_tag_next;
  logic        color_pending, color_pending_next;
  logic [11:0] cursor_col, cursor_col_next;
  logic [11:0] cursor_row, cursor_row_next;
  logic [23:0] active_color, active_color_next;

  // page_start applies the fresh-page values before the byte is used
  logic [2:0]  hp_e;
  logic        body_e, tag_e, pend_e;
  logic [11:0] col_e, row_e, row_home;
  logic [23:0] color_e;
  logic [12:0] row_sum;
  logic [11:0] row_fed;
  logic [13:0] col_reach;
  logic [7:0]  want;

  assign row_home = {2'b00, cfg.bar_height} + TOP_GAP;

  always_comb begin
    hp_e    = page_start ? 3'd0 : header_progress;
    body_e  = page_start ? 1'b0 : in_body;
    tag_e   = page_start ? 1'b0 : inside_tag;
    pend_e  = page_start ? 1'b0 : color_pending;
    col_e   = page_start ? LEFT_MARGIN : cursor_col;
    row_e   = page_start ? row_home : cursor_row;
    color_e = page_start ? cfg.text_color : active_color;

    row_sum   = {1'b0, row_e} + {1'b0, LINE_H};
    row_fed   = (row_sum > {1'b0, ROW_MAX}) ? ROW_MAX : row_sum[11:0];
    // wrap when col + 8 > width - 20, kept unsigned by moving the margin over
    col_reach = {2'b00, col_e} + {2'b00, GLYPH_W} + {2'b00, LEFT_MARGIN};
    want      = hp_e[0] ? CH_LF : CH_CR;

    header_progress_next = hp_e;
    in_body_next         = body_e;
    inside_tag_next      = tag_e;
    color_pending_next   = pend_e;
    cursor_col_next      = col_e;
    cursor_row_next      = row_e;
    active_color_next    = color_e;
    emit                 = 1'b0;

    glyph.x     = col_e;
    glyph.y     = row_e;
    glyph.ch    = byte_in;
    glyph.color = color_e;

    if (cfg.skip_header && !body_e) begin
      if (byte_in == want) begin
        if (hp_e == 3'd3) begin
          header_progress_next = 3'd0;
          in_body_next         = 1'b1;
        end else begin
          header_progress_next = hp_e + 3'd1;
        end
      end else begin
        header_progress_next = (byte_in == CH_CR) ? 3'd1 : 3'd0;
      end
    end else begin
      color_pending_next = 1'b0;
      if (pend_e) begin
        if (byte_in == CH_H_LO || byte_in == CH_H_UP) begin
          active_color_next = cfg.heading_color;
        end else if (byte_in == CH_A_LO || byte_in == CH_A_UP) begin
          active_color_next = cfg.link_color;
        end else if (byte_in == CH_SLASH) begin
          active_color_next = cfg.text_color;
        end
      end
      glyph.color = active_color_next;

      if (byte_in == CH_LT) begin
        inside_tag_next    = 1'b1;
        color_pending_next = 1'b1;
      end else if (byte_in == CH_GT) begin
        inside_tag_next = 1'b0;
      end else if (tag_e) begin
        // drop markup body
      end else if (byte_in == CH_LF) begin
        cursor_col_next = LEFT_MARGIN;
        cursor_row_next = row_fed;
      end else begin
        emit = 1'b1;
        if (col_reach > {2'b00, cfg.screen_width}) begin
          cursor_col_next = LEFT_MARGIN;
          cursor_row_next = row_fed;
        end else begin
          cursor_col_next = col_e + GLYPH_W;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_progress <= 3'd0;
      in_body         <= 1'b0;
      inside_tag      <= 1'b0;
      color_pending   <= 1'b0;
      cursor_col      <= LEFT_MARGIN;
      cursor_row      <= {2'b00, RST_BAR_HEIGHT} + TOP_GAP;
      active_color    <= RST_TEXT_COLOR;
    end else if (accept) begin
      header_progress <= header_progress_next;
      in_body         <= in_body_next;
      inside_tag      <= inside_tag_next;
      color_pending   <= color_pending_next;
      cursor_col      <= cursor_col_next;
      cursor_row      <= cursor_row_next;
      active_color    <= active_color_next;
    end
  end

  // columns advance in steps of 8 from the margin, so the low bits stay fixed
  a_col_grid: assert property (@(posedge clk) disable iff (rst)
    cursor_col[2:0] == LEFT_MARGIN[2:0] && cursor_col >= LEFT_MARGIN)
    else $error("cursor column off the glyph grid");

  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    header_progress <= 3'd3)
    else $error("header match count out of range");

  a_body_hdr: assert property (@(posedge clk) disable iff (rst)
    accept && emit |=> !(cfg.skip_header && !in_body && header_progress != 3'd0
                         && $past(cfg.skip_header)))
    else $error("header matching resumed after a glyph");

endmodule

// ----- src/markup_text_glyph_placer.sv -----
// Top level of the markup text glyph placer: config registers and a two-entry
// result buffer around mtgp_step. Depends on mtgp_pkg and mtgp_step.
//
//  channel | signals                                         | dir
//  in      | in_valid, in_ready, byte_in, page_start         | in
//  out     | out_valid, out_ready, glyph_x/y/char/color      | out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data       | in
//
// One byte per cycle while in_ready is high; a glyph shows on out in the cycle after
// its byte is taken when the output slot is free, later while out_ready holds it back.
// The per-byte work is one pass through mtgp_step into the result register.
// A skid register holds one more result, so in_ready only drops when both are full.
// rst (synchronous) restores register defaults, a fresh page and an empty buffer.
// cfg_ready is always high; write only while idle.
module markup_text_glyph_placer import mtgp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        page_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] glyph_x,
  output logic [11:0] glyph_y,
  output logic [7:0]  glyph_char,
  output logic [23:0] glyph_color,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_regs_t cfg;
  glyph_t    step_glyph, main_glyph, skid_glyph;
  logic      emit, accept, pop, push, skid_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= RST_SCREEN_WIDTH;
      cfg.bar_height    <= RST_BAR_HEIGHT;
      cfg.text_color    <= RST_TEXT_COLOR;
      cfg.heading_color <= RST_HEADING_COLOR;
      cfg.link_color    <= RST_LINK_COLOR;
      cfg.skip_header   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[11:0];
        REG_BAR_HEIGHT:    cfg.bar_height    <= cfg_data[9:0];
        REG_TEXT_COLOR:    cfg.text_color    <= cfg_data;
        REG_HEADING_COLOR: cfg.heading_color <= cfg_data;
        REG_LINK_COLOR:    cfg.link_color    <= cfg_data;
        REG_SKIP_HEADER:   cfg.skip_header   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign push     = accept && emit;

  mtgp_step u_step (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_in    (byte_in),
    .page_start (page_start),
    .cfg        (cfg),
    .emit       (emit),
    .glyph      (step_glyph)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the skid word into the output slot
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) main_glyph <= skid_glyph;
    end else if (!out_valid || pop) begin
      main_glyph <= step_glyph;
    end else if (push) begin
      skid_glyph <= step_glyph;
    end
  end

  assign glyph_x     = main_glyph.x;
  assign glyph_y     = main_glyph.y;
  assign glyph_char  = main_glyph.ch;
  assign glyph_color = main_glyph.color;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output slot");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_ready |=> skid_valid && $stable(skid_glyph))
    else $error("skid word lost while output stalled");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push && !out_valid |=> out_valid && !skid_valid)
    else $error("result dropped from empty buffer");

endmodule

// ----- tb/markup_text_glyph_placer_test.sv -----
// Self-checking testbench for markup_text_glyph_placer: directed bytes, then random pages.
// Depends on mtgp_pkg and the RTL under src; predicts each glyph in a scoreboard class.
module markup_text_glyph_placer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mtgp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN_MAX   = 10;
  localparam int BODY_GOAL   = 30;

  class glyph_scoreboard;
    cfg_regs_t   regs;
    logic [2:0]  crlf_seen;
    bit          in_body;
    bit          in_tag;
    bit          color_pick;
    int          col;
    int          row;
    logic [23:0] pen;
    glyph_t      glyphs_due[$];
    int          mismatches;
    int          glyphs_checked;
    int          bytes_seen;
    int          body_bytes;

    function new();
      regs.screen_width  = RST_SCREEN_WIDTH;
      regs.bar_height    = RST_BAR_HEIGHT;
      regs.text_color    = RST_TEXT_COLOR;
      regs.heading_color = RST_HEADING_COLOR;
      regs.link_color    = RST_LINK_COLOR;
      regs.skip_header   = 1'b1;
      mismatches = 0;
      glyphs_checked = 0;
      bytes_seen = 0;
      body_bytes = 0;
      start_page();
    endfunction

    function void start_page();
      crlf_seen = 3'd0;
      in_body = 0;
      in_tag = 0;
      color_pick = 0;
      col = int'(LEFT_MARGIN);
      row = int'(regs.bar_height) + int'(TOP_GAP);
      pen = regs.text_color;
    endfunction

    function void feed_line();
      col = int'(LEFT_MARGIN);
      row = (row + int'(LINE_H) > int'(ROW_MAX)) ? int'(ROW_MAX) : row + int'(LINE_H);
    endfunction

    function void write_reg(reg_index_t idx, logic [23:0] data);
      case (idx)
        REG_SCREEN_WIDTH: regs.screen_width = data[11:0];
        REG_BAR_HEIGHT: regs.bar_height = data[9:0];
        REG_TEXT_COLOR: regs.text_color = data;
        REG_HEADING_COLOR: regs.heading_color = data;
        REG_LINK_COLOR: regs.link_color = data;
        REG_SKIP_HEADER: regs.skip_header = data[0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic ps);
      glyph_t g;
      bytes_seen++;
      if (ps) start_page();
      if (regs.skip_header && !in_body) begin
        // a CR that breaks a match still counts as the start of a new one
        if (b == (crlf_seen[0] ? CH_LF : CH_CR)) begin
          crlf_seen++;
          if (crlf_seen >= 3'd4) begin
            crlf_seen = 3'd0;
            in_body = 1;
          end
        end else begin
          crlf_seen = (b == CH_CR) ? 3'd1 : 3'd0;
        end
        return;
      end
      body_bytes++;
      if (color_pick) begin
        color_pick = 0;
        if (b == CH_H_LO || b == CH_H_UP) pen = regs.heading_color;
        else if (b == CH_A_LO || b == CH_A_UP) pen = regs.link_color;
        else if (b == CH_SLASH) pen = regs.text_color;
      end
      if (b == CH_LT) begin
        in_tag = 1;
        color_pick = 1;
        return;
      end
      if (b == CH_GT) begin
        in_tag = 0;
        return;
      end
      if (in_tag) return;
      if (b == CH_LF) begin
        feed_line();
        return;
      end
      g.x = col[11:0];
      g.y = row[11:0];
      g.ch = b;
      g.color = pen;
      glyphs_due.push_back(g);
      col += int'(GLYPH_W);
      // width below the margin makes the limit negative: every glyph wraps
      if (col > int'(regs.screen_width) - int'(LEFT_MARGIN)) feed_line();
      col &= 'hFFF;
    endfunction

    function void flag(string what, glyph_t want, glyph_t got);
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("%t %s: want x=%0d y=%0d ch=%h color=%h, got x=%0d y=%0d ch=%h color=%h",
                 $realtime, what, want.x, want.y, want.ch, want.color,
                 got.x, got.y, got.ch, got.color);
    endfunction

    function void check_glyph(glyph_t got);
      glyph_t want;
      if (glyphs_due.size() == 0) begin
        want = '0;
        flag("glyph with none expected", want, got);
        return;
      end
      want = glyphs_due.pop_front();
      glyphs_checked++;
      if (got.x !== want.x || got.y !== want.y || got.ch !== want.ch ||
          got.color !== want.color)
        flag("glyph mismatch", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  byte_in = 8'h00;
  logic        page_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] glyph_x;
  logic [11:0] glyph_y;
  logic [7:0]  glyph_char;
  logic [23:0] glyph_color;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [23:0] cfg_data = 24'h0;

  glyph_scoreboard board;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  cycle_count = 0;
  int  pages_sent = 0;
  int  settings_done = 0;
  bit  fresh_page = 0;

  markup_text_glyph_placer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in), .page_start(page_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .glyph_x(glyph_x), .glyph_y(glyph_y), .glyph_char(glyph_char), .glyph_color(glyph_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_glyph('{x: glyph_x, y: glyph_y, ch: glyph_char, color: glyph_color});
  end

  // call at a falling edge; returns at the falling edge after the word is taken
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    byte_in = b;
    page_start = fresh_page;
    do @(posedge clk); while (!in_ready);
    board.note_byte(b, fresh_page);
    fresh_page = 0;
    @(negedge clk);
  endtask

  task automatic set_reg(input reg_index_t idx, input logic [23:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold until every glyph is back, then let dropped bytes settle
  task automatic drain();
    in_valid = 1'b0;
    while (board.glyphs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_token();
    int r;
    int n;
    logic [7:0] sel;
    r = $urandom_range(99);
    if (r < 5) begin
      push_byte(8'($urandom_range(255)));
    end else if (r < 22) begin
      case ($urandom_range(5))
        0: sel = CH_H_LO;
        1: sel = CH_H_UP;
        2: sel = CH_A_LO;
        3: sel = CH_A_UP;
        4: sel = CH_SLASH;
        default: sel = 8'($urandom_range(8'h20, 8'h7E));
      endcase
      push_byte(CH_LT);
      push_byte(sel);
      n = $urandom_range(3);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 10) push_byte(CH_LF);
        else if (r < 15) push_byte(CH_LT);
        else push_byte(8'($urandom_range(8'h61, 8'h7A)));
      end
      if ($urandom_range(19) != 0) push_byte(CH_GT);
    end else if (r < 30) begin
      push_byte(CH_LF);
    end else if (r < 33) begin
      push_byte(CH_GT);
    end else if (r < 38) begin
      n = $urandom_range(8, 40);
      repeat (n) push_byte(8'($urandom_range(8'h61, 8'h7A)));
    end else begin
      push_byte(8'($urandom_range(8'h20, 8'h7E)));
    end
  endtask

  task automatic send_page(input int tokens);
    int n;
    int r;
    fresh_page = 1;
    pages_sent++;
    if (board.regs.skip_header) begin
      n = $urandom_range(6);
      repeat (n) begin
        r = $urandom_range(9);
        if (r < 2) push_byte(CH_CR);
        else if (r < 4) push_byte(CH_LF);
        else push_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(3) == 0) begin
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      // leave a few pages without a blank line so the body stays hidden
      if ($urandom_range(9) != 0) begin
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
    end
    repeat (tokens) send_token();
  endtask

  initial begin
    logic [7:0] opening[$];
    logic [23:0] setting[6];
    int goal;

    board = new();
    opening = '{"G", CH_CR, CH_CR, CH_LF, CH_CR, CH_LF,
                "A", CH_LT, CH_H_LO, CH_GT, "B", CH_LT, CH_LT, CH_A_UP, CH_GT, CH_GT,
                CH_LT, CH_LF, CH_GT, 8'h00, CH_CR, CH_LF, 8'hFF,
                CH_LT, CH_SLASH, CH_GT, CH_LT, CH_H_UP, "i", CH_GT, "D"};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 80;
    fresh_page = 1;
    pages_sent++;
    foreach (opening[i]) push_byte(opening[i]);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: setting = '{12'($urandom_range(64, 4095)), 10'($urandom_range(1023)),
                       24'($urandom), 24'($urandom), 24'($urandom), 24'd1};
        1: setting = '{12'd64, 10'd0, 24'h000000, 24'hFFFFFF, 24'h000000, 24'd0};
        2: setting = '{12'd4095, 10'd1023, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'd1};
        // narrow screen on the lowest start row: the row runs into its ceiling
        3: setting = '{12'd8, 10'd1023, 24'($urandom), 24'($urandom), 24'($urandom), 24'd0};
        4: setting = '{12'($urandom_range(0, 4095)), 10'($urandom_range(1023)),
                       24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom_range(1))};
        default: setting = '{12'd100, 10'($urandom_range(1023)),
                             24'($urandom), 24'($urandom), 24'($urandom), 24'd1};
      endcase
      set_reg(REG_SCREEN_WIDTH, setting[0]);
      set_reg(REG_BAR_HEIGHT, setting[1]);
      set_reg(REG_TEXT_COLOR, setting[2]);
      set_reg(REG_HEADING_COLOR, setting[3]);
      set_reg(REG_LINK_COLOR, setting[4]);
      set_reg(REG_SKIP_HEADER, setting[5]);
      settings_done++;

      if (p < 2) begin
        send_idle_pct = 30;
        recv_idle_pct = 80;
      end else if (p < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      goal = board.body_bytes + BODY_GOAL;
      if (p == 3) begin
        send_page(120);
      end else begin
        while (board.body_bytes < goal) send_page($urandom_range(5, 50));
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.glyphs_due.size() != 0) board.mismatches++;
    $display("Covered %0d bytes (%0d past the header) over %0d pages and %0d register settings.",
             board.bytes_seen, board.body_bytes, pages_sent, settings_done);
    $display("Checked %0d glyphs, %0d failures.", board.glyphs_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/mtgp_pkg.sv
src/mtgp_step.sv
src/markup_text_glyph_placer.sv
tb/markup_text_glyph_placer_test.sv
